FILE: rtl/core/mip_level_box_downsample_top_macros.svh
// Assertion helpers for the mip level downsampler.
// Every check is clocked on clk and switched off while rst_n is low.
`ifndef MIP_LEVEL_BOX_DOWNSAMPLE_TOP_MACROS_SVH
`define MIP_LEVEL_BOX_DOWNSAMPLE_TOP_MACROS_SVH

// Check that a condition holds at every edge.
`define MLB_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its trigger.
`define MLB_CHECK_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its trigger.
`define MLB_CHECK_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mlb_pkg.sv
package mlb_pkg;

    localparam int CFG_W      = 11;
    localparam int CHAN_W     = 3;
    localparam int DATA_W     = 32;
    localparam int PAIR_W     = DATA_W + 1;
    localparam int SUM_W      = DATA_W + 2;
    localparam int NUM_CH     = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_HALF_WIDTH  = 1024;
    localparam int DEF_MAX_HALF_HEIGHT = 1024;

    localparam logic [CFG_W-1:0]  RESET_HALF_WIDTH    = CFG_W'(1);
    localparam logic [CFG_W-1:0]  RESET_HALF_HEIGHT   = CFG_W'(1);
    localparam logic [CHAN_W-1:0] RESET_CHANNEL_COUNT = CHAN_W'(4);

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_WIDTH    = 2'd0,
        REG_HALF_HEIGHT   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    // what the back end does with a queued pair
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_EMIT  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                             op;
        logic                            last;
        logic [NUM_CH-1:0]               chan_mask;
        logic [NUM_CH-1:0][PAIR_W-1:0]   pair;
    } job_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

endpackage

FILE: rtl/core/mlb_front.sv
module mlb_front
    import mlb_pkg::*;
#(
    parameter int MAX_HALF_WIDTH  = DEF_MAX_HALF_WIDTH,
    parameter int MAX_HALF_HEIGHT = DEF_MAX_HALF_HEIGHT,
    parameter int IDX_W           = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CFG_W-1:0]         half_width,
    input  logic [CFG_W-1:0]         half_height,
    input  logic [CHAN_W-1:0]        channel_count,
    input  logic                     accept,
    input  logic [NUM_CH-1:0][DATA_W-1:0] in_ch,
    output logic                     push,
    output job_t                     push_job,
    output logic [IDX_W-1:0]         push_idx
);

    localparam int ROWIDX_W = (MAX_HALF_HEIGHT > 1) ? $clog2(MAX_HALF_HEIGHT) : 1;
    localparam int COL_W    = IDX_W + 1;
    localparam int ROW_W    = ROWIDX_W + 1;
    localparam int CW_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int RW_W     = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [NUM_CH-1:0][DATA_W-1:0] left_reg, left_next;

    logic [CW_W-1:0]   hw, sw, col_ext, col_eff, col_inc;
    logic [RW_W-1:0]   hh, sh, row_ext, row_eff, row_inc;
    logic [CHAN_W-1:0] chans;
    logic              out_of_range;

    // clamp sizes to the supported range, zero counts as one
    always_comb
    begin
        if (half_width == '0)
            hw = CW_W'(1);
        else if (CW_W'(half_width) > CW_W'(MAX_HALF_WIDTH))
            hw = CW_W'(MAX_HALF_WIDTH);
        else
            hw = CW_W'(half_width);

        if (half_height == '0)
            hh = RW_W'(1);
        else if (RW_W'(half_height) > RW_W'(MAX_HALF_HEIGHT))
            hh = RW_W'(MAX_HALF_HEIGHT);
        else
            hh = RW_W'(half_height);

        if (channel_count == '0)
            chans = CHAN_W'(1);
        else if (channel_count > CHAN_W'(NUM_CH))
            chans = CHAN_W'(NUM_CH);
        else
            chans = channel_count;
    end

    assign sw = hw << 1;
    assign sh = hh << 1;

    assign col_ext = CW_W'(col_reg);
    assign row_ext = RW_W'(row_reg);

    // restart at the top left when the stored position no longer fits the level
    assign out_of_range = (col_ext >= sw) || (row_ext >= sh);
    assign col_eff      = out_of_range ? '0 : col_ext;
    assign row_eff      = out_of_range ? '0 : row_ext;
    assign col_inc      = col_eff + CW_W'(1);
    assign row_inc      = row_eff + RW_W'(1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (accept)
        begin
            if (!col_eff[0])
                left_next = in_ch;
            if (col_inc >= sw)
            begin
                col_next = '0;
                row_next = (row_inc >= sh) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_eff[ROW_W-1:0];
            end
        end
    end

    always_comb
    begin
        push_job.op   = row_eff[0] ? OP_EMIT : OP_STORE;
        push_job.last = (row_eff == sh - RW_W'(1)) && (col_eff == sw - CW_W'(1));
        for (int c = 0; c < NUM_CH; c++)
        begin
            push_job.chan_mask[c] = (CHAN_W'(c) < chans);
            push_job.pair[c]      = {left_reg[c][DATA_W-1], left_reg[c]}
                                  + {in_ch[c][DATA_W-1], in_ch[c]};
        end
    end

    assign push     = accept && col_eff[0];
    assign push_idx = col_eff[COL_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
    end

endmodule

FILE: rtl/core/mlb_queue.sv
module mlb_queue
    import mlb_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_stat_t          stat
);

    logic [WIDTH-1:0]   slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + Q_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + Q_PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

FILE: rtl/core/mlb_back.sv
module mlb_back
    import mlb_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
    parameter int IDX_W          = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  job_t                          q_job,
    input  logic [IDX_W-1:0]              q_idx,
    output logic                          pop,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [NUM_CH-1:0][DATA_W-1:0] out_ch,
    output logic                          out_last
);

    // horizontal pair sums of the even row, one word per destination column
    logic [NUM_CH*PAIR_W-1:0] row_mem [MAX_HALF_WIDTH];
    logic [NUM_CH*PAIR_W-1:0] rd_reg;

    logic advance;
    logic s1_valid_reg, s1_valid_next;
    job_t s1_job_reg;
    logic out_valid_reg, out_valid_next;
    logic [NUM_CH-1:0][DATA_W-1:0] out_ch_reg, out_ch_next;
    logic out_last_reg;

    logic [NUM_CH-1:0][PAIR_W-1:0] upper;
    logic [SUM_W-1:0]              total;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_empty;
    assign upper   = rd_reg;

    always_ff @(posedge clk)
    begin
        if (pop && (q_job.op == OP_STORE))
            row_mem[q_idx] <= q_job.pair;
        if (pop && (q_job.op == OP_EMIT))
            rd_reg <= row_mem[q_idx];
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = pop && (q_job.op == OP_EMIT);
            out_valid_next = s1_valid_reg;
        end
    end

    // add the two row sums and floor-divide by four; channels beyond the count give zero
    always_comb
    begin
        total = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            total = {upper[c][PAIR_W-1], upper[c]}
                  + {s1_job_reg.pair[c][PAIR_W-1], s1_job_reg.pair[c]};
            out_ch_next[c] = s1_job_reg.chan_mask[c] ? total[SUM_W-1:2] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_job_reg <= q_job;
        if (advance)
        begin
            out_ch_reg   <= out_ch_next;
            out_last_reg <= s1_job_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ch    = out_ch_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/core/mip_level_box_downsample_top.sv
// The item that completes a block passes the job queue, stage-one and output registers to out_valid.
// Throughput: one source item per cycle; the back pops one job per cycle unless out_stall holds it,
// and the row-sum memory sees at most one access per two source items, so in_stall rises only
// on a full queue. A four-entry queue decouples position tracking from the memory and averaging
// pipeline. Reset (rst_n, asynchronous, active low) clears position, queue, pipeline valids and
// loads the default sizes; the row-sum memory is not cleared and needs no clearing pass.
module mip_level_box_downsample_top
    import mlb_pkg::*;
#(
    parameter int MAX_HALF_WIDTH  = DEF_MAX_HALF_WIDTH,
    parameter int MAX_HALF_HEIGHT = DEF_MAX_HALF_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] in_ch0,
    input  logic signed [DATA_W-1:0] in_ch1,
    input  logic signed [DATA_W-1:0] in_ch2,
    input  logic signed [DATA_W-1:0] in_ch3,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] out_ch0,
    output logic signed [DATA_W-1:0] out_ch1,
    output logic signed [DATA_W-1:0] out_ch2,
    output logic signed [DATA_W-1:0] out_ch3,
    output logic                     out_last
);

    localparam int IDX_W = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
    localparam int Q_W   = IDX_W + $bits(job_t);

    // configuration registers; to be written only while the block is idle, which the block does not enforce
    logic [CFG_W-1:0]  half_width_reg, half_width_next;
    logic [CFG_W-1:0]  half_height_reg, half_height_next;
    logic [CHAN_W-1:0] channel_count_reg, channel_count_next;

    always_comb
    begin
        half_width_next    = half_width_reg;
        half_height_next   = half_height_reg;
        channel_count_next = channel_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_WIDTH:    half_width_next    = cfg_data;
                REG_HALF_HEIGHT:   half_height_next   = cfg_data;
                REG_CHANNEL_COUNT: channel_count_next = cfg_data[CHAN_W-1:0];
                default:           ;   // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg    <= RESET_HALF_WIDTH;
            half_height_reg   <= RESET_HALF_HEIGHT;
            channel_count_reg <= RESET_CHANNEL_COUNT;
        end
        else
        begin
            half_width_reg    <= half_width_next;
            half_height_reg   <= half_height_next;
            channel_count_reg <= channel_count_next;
        end
    end

    // front: track the source position, hold the even-column pixel and
    // form the horizontal pair sums; only odd-column items enter the queue
    logic                          in_accept;
    logic                          q_push;
    logic                          q_pop;
    job_t                          front_job;
    logic [IDX_W-1:0]              front_idx;
    logic [Q_W-1:0]                q_head;
    q_stat_t                       q_stat;
    logic [NUM_CH-1:0][DATA_W-1:0] in_ch;
    logic [NUM_CH-1:0][DATA_W-1:0] out_ch;
    logic [Q_CNT_W-1:0]            q_count_want;

    // stall on a full queue alone, so an item is never refused for the output side
    assign in_stall  = q_stat.full;
    assign in_accept = in_valid && !in_stall;
    assign in_ch     = {in_ch3, in_ch2, in_ch1, in_ch0};

    mlb_front #(
        .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
        .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT),
        .IDX_W           (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .half_width    (half_width_reg),
        .half_height   (half_height_reg),
        .channel_count (channel_count_reg),
        .accept        (in_accept),
        .in_ch         (in_ch),
        .push          (q_push),
        .push_job      (front_job),
        .push_idx      (front_idx)
    );

    mlb_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_idx, front_job}),
        .pop       (q_pop),
        .pop_data  (q_head),
        .stat      (q_stat)
    );

    // back: store even-row pair sums, or read the stored sum back, add,
    // divide by four and hold the result in the output register
    mlb_back #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .IDX_W          (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_stat.empty),
        .q_job     (q_head[$bits(job_t)-1:0]),
        .q_idx     (q_head[Q_W-1:$bits(job_t)]),
        .pop       (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_ch    (out_ch),
        .out_last  (out_last)
    );

    assign out_ch0 = out_ch[0];
    assign out_ch1 = out_ch[1];
    assign out_ch2 = out_ch[2];
    assign out_ch3 = out_ch[3];

    // occupancy expected after this edge's push and pop
    assign q_count_want = q_stat.count + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);

`include "mip_level_box_downsample_top_macros.svh"

    // the front must never push into a full queue
    `MLB_CHECK_IMPLY(a_no_push_when_full, q_push, !q_stat.full, "push into full queue")
    // occupancy stays within the queue depth
    `MLB_CHECK(a_count_bound, q_stat.count <= Q_CNT_W'(QUEUE_DEPTH), "queue count over depth")
    // occupancy follows pushes and pops exactly
    `MLB_CHECK_NEXT(a_count_track, 1'b1, q_stat.count == $past(q_count_want), "queue count drift")

endmodule

FILE: bench/tb_mip_level_box_downsample_top.sv
module tb_mip_level_box_downsample_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlb_pkg::*;

    // Index 3 of the register port maps to no register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // The stage-one and output registers plus the four-entry job queue, with margin.
    localparam int DRAIN_CYCLES = 16;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;

    typedef logic [NUM_CH-1:0][DATA_W-1:0] src_pixel_t;

    // One destination pixel as the block should present it.
    typedef struct packed {
        logic [NUM_CH-1:0][DATA_W-1:0] ch;
        logic                          last;
    } mip_pixel_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] in_ch0    = '0;
    logic signed [DATA_W-1:0] in_ch1    = '0;
    logic signed [DATA_W-1:0] in_ch2    = '0;
    logic signed [DATA_W-1:0] in_ch3    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] out_ch0;
    logic signed [DATA_W-1:0] out_ch1;
    logic signed [DATA_W-1:0] out_ch2;
    logic signed [DATA_W-1:0] out_ch3;
    logic                     out_last;

    mip_level_box_downsample_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_ch0    (in_ch0),
        .in_ch1    (in_ch1),
        .in_ch2    (in_ch2),
        .in_ch3    (in_ch3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ch0   (out_ch0),
        .out_ch1   (out_ch1),
        .out_ch2   (out_ch2),
        .out_ch3   (out_ch3),
        .out_last  (out_last)
    );

    // Idling percentages of the current phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatches  = 0;
    int unsigned n_src_items = 0;
    int unsigned n_dst_items = 0;
    int unsigned n_levels    = 0;

    // Shadow of the configuration registers, raw as written.
    int unsigned width_reg   = RESET_HALF_WIDTH;
    int unsigned height_reg  = RESET_HALF_HEIGHT;
    int unsigned channel_reg = RESET_CHANNEL_COUNT;

    // Shadow of the position tracker, the pending left pixel and the even-row pair sums.
    int unsigned column_at = 0;
    int unsigned row_at    = 0;
    longint      left_px [NUM_CH];
    longint      even_row_pairs [NUM_CH][DEF_MAX_HALF_WIDTH];

    // Averages predicted but not yet seen on the output, oldest first.
    mip_pixel_t  awaited_averages [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
        return (v < 1) ? 1 : ((v > top) ? top : v);
    endfunction

    function automatic int unsigned level_items();
        return 4 * clamp_dim(width_reg, DEF_MAX_HALF_WIDTH)
                 * clamp_dim(height_reg, DEF_MAX_HALF_HEIGHT);
    endfunction

    // Advance the shadow by one accepted source pixel; queue the average it completes.
    task automatic downsample_pixel(input src_pixel_t px);
        int unsigned src_w;
        int unsigned src_h;
        int unsigned n_ch;
        int unsigned col;
        int unsigned row;
        longint      pair;
        longint      total;
        mip_pixel_t  avg;
        src_w = 2 * clamp_dim(width_reg, DEF_MAX_HALF_WIDTH);
        src_h = 2 * clamp_dim(height_reg, DEF_MAX_HALF_HEIGHT);
        n_ch  = clamp_dim(channel_reg, NUM_CH);
        col   = column_at;
        row   = row_at;
        avg   = '0;
        // A position left outside the level by a resize restarts the level.
        if (col >= src_w || row >= src_h)
        begin
            col = 0;
            row = 0;
        end
        if (col % 2 == 0)
        begin
            for (int c = 0; c < NUM_CH; c++)
                left_px[c] = $signed(px[c]);
        end
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                pair = left_px[c] + $signed(px[c]);
                if (row % 2 == 0)
                    even_row_pairs[c][col / 2] = pair;
                else
                begin
                    total = even_row_pairs[c][col / 2] + pair;
                    if (c < n_ch)
                        avg.ch[c] = 32'(total >>> 2);
                end
            end
            if (row % 2 == 1)
            begin
                avg.last = (row == src_h - 1) && (col == src_w - 1);
                awaited_averages.push_back(avg);
            end
        end
        col++;
        if (col >= src_w)
        begin
            col = 0;
            row++;
            if (row >= src_h)
                row = 0;
        end
        column_at = col;
        row_at    = row;
    endtask

    // Offer one pixel, idling first as the phase asks; return once it is taken.
    // Valid is left high so that a following item goes out back to back.
    task automatic send_pixel(input src_pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ch0   <= px[0];
        in_ch1   <= px[1];
        in_ch2   <= px[2];
        in_ch3   <= px[3];
        do
            @(posedge clk);
        while (in_stall);
        n_src_items++;
        downsample_pixel(px);
    endtask

    // Drop valid and hold until every awaited average has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_averages.size() != 0);
    endtask

    // Drain, then let items that produce nothing clear the queue and pipeline.
    task automatic settle();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the enable is left high for back-to-back writes.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_HALF_WIDTH:    width_reg   = val;
            REG_HALF_HEIGHT:   height_reg  = val;
            REG_CHANNEL_COUNT: channel_reg = val[CHAN_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] chans);
        settle();
        cfg_write(REG_HALF_WIDTH, w);
        cfg_write(REG_HALF_HEIGHT, h);
        cfg_write(REG_CHANNEL_COUNT, chans);
        cfg_we <= 1'b0;
    endtask

    // Bias towards the extremes and tiny values so floors and carries get exercised.
    function automatic logic [DATA_W-1:0] rand_channel();
        case ($urandom_range(9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '1;
            3:       return DATA_W'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    function automatic src_pixel_t rand_pixel();
        src_pixel_t px;
        for (int c = 0; c < NUM_CH; c++)
            px[c] = rand_channel();
        return px;
    endfunction

    // Stream one whole level of random pixels, optionally draining at a random point.
    task automatic send_level(input bit with_pause);
        int unsigned total;
        int unsigned pause_at;
        total    = level_items();
        pause_at = with_pause ? $urandom_range(total - 1) : total;
        for (int unsigned i = 0; i < total; i++)
        begin
            if (i == pause_at && i != 0)
                drain();
            send_pixel(rand_pixel());
        end
        n_levels++;
    endtask

    // Reset sizes (one 2x2 block, four channels): saturated sums and flooring of
    // small negative and positive quarters, one channel per case.
    task automatic test_block_arithmetic();
        send_pixel({32'd1, 32'hffff_ffff, Q_MAX, Q_MIN});
        send_pixel({32'd1, 32'd0,         Q_MAX, Q_MIN});
        send_pixel({32'd1, 32'd0,         Q_MAX, Q_MIN});
        send_pixel({32'd0, 32'd0,         Q_MAX, Q_MIN});
        send_pixel({32'd5, 32'hffff_fffe, Q_MIN, Q_MAX});
        send_pixel({32'd0, 32'hffff_ffff, Q_MIN, Q_MAX});
        send_pixel({32'd0, 32'd0,         Q_MIN, Q_MAX});
        send_pixel({32'd0, 32'd0,         Q_MIN, Q_MAX});
        n_levels += 2;
    endtask

    // Shrink the height while the position sits in an even row beyond the new
    // level: the next item must restart the level at its first pixel.
    task automatic test_resize_restart();
        configure(11'd1, 11'd3, 11'd4);
        repeat (9) send_pixel(rand_pixel());
        configure(11'd1, 11'd2, 11'd3);
        send_level(1'b0);
    endtask

    // Zero sizes and channel count, oversize registers taken part way into their
    // level, junk above the count field and a write to the unmapped index.
    task automatic test_register_extremes();
        configure(11'd0, 11'd0, 11'd0);
        send_level(1'b0);
        // Tall level: 24 source rows, averages every second row, then leave it.
        configure(11'd1, 11'h7ff, {8'($urandom), 3'd6});
        repeat (48) send_pixel(rand_pixel());
        // Wide level: part of the first row only; the next level restarts at the top left.
        configure(11'h7ff, 11'd1, {8'($urandom), 3'd5});
        repeat (24) send_pixel(rand_pixel());
        settle();
        cfg_write(REG_UNUSED, 11'($urandom));
        cfg_we <= 1'b0;
        configure(11'd3, 11'd2, 11'd2);
        send_level(1'b1);
    endtask

    // Random levels of mostly small sizes, back to back or reconfigured in between.
    task automatic test_random_levels(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned n_items);
        int unsigned start;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        start          = n_src_items;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n_src_items - start < n_items)
        begin
            if (n_src_items == start || $urandom_range(1) == 0)
            begin
                if ($urandom_range(7) == 0)
                begin
                    w = 11'($urandom_range(7, 40));
                    h = 11'd1;
                end
                else
                begin
                    w = 11'($urandom_range(0, 6));
                    h = 11'($urandom_range(0, 4));
                end
                configure(w, h, {8'($urandom), 3'($urandom_range(7))});
            end
            send_level($urandom_range(3) == 0);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Output side: check each accepted average against the oldest prediction,
    // then pick the stall for the next cycle.
    always @(posedge clk)
    begin : result_sink
        src_pixel_t got;
        mip_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_ch3, out_ch2, out_ch1, out_ch0};
            if (awaited_averages.size() == 0)
                report_mismatch($sformatf("unexpected pixel %h last %b", got, out_last));
            else
            begin
                want = awaited_averages.pop_front();
                for (int c = 0; c < NUM_CH; c++)
                    if (got[c] !== want.ch[c])
                        report_mismatch($sformatf("pixel %0d ch%0d: got %h, want %h",
                                                  n_dst_items, c, got[c], want.ch[c]));
                if (out_last !== want.last)
                    report_mismatch($sformatf("pixel %0d last: got %b, want %b",
                                              n_dst_items, out_last, want.last));
            end
            n_dst_items++;
        end
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        // Hold reset at the start, release once and never again.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_block_arithmetic();
        test_resize_restart();
        test_register_extremes();
        test_random_levels(0, 0, 60);
        test_random_levels(67, 0, 60);
        test_random_levels(0, 67, 60);
        test_random_levels(33, 33, 60);

        settle();
        $display("tb: %0d source items, %0d averaged pixels over %0d levels",
                 n_src_items, n_dst_items, n_levels);
        $display("tb: covered saturated and floored sums, size and channel extremes, resize");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mlb_pkg.sv
rtl/core/mlb_front.sv
rtl/core/mlb_queue.sv
rtl/core/mlb_back.sv
rtl/core/mip_level_box_downsample_top.sv
bench/tb_mip_level_box_downsample_top.sv
